[sv/dlc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Diff line classifier package
// Shared sizes, class codes, sequencer push codes and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dlc_pkg;

   // Longest leading letter word that is held before the line goes plain.
   localparam int WORD_LIMIT  = 16;
   localparam int STASH_IDX_W = $clog2(WORD_LIMIT);
   localparam int COUNT_W     = $clog2(WORD_LIMIT + 1);

   // Line class codes carried on out_class.
   localparam logic [2:0] CL_PLAIN = 3'd0;
   localparam logic [2:0] CL_ADD   = 3'd1;
   localparam logic [2:0] CL_REM   = 3'd2;
   localparam logic [2:0] CL_HUNK  = 3'd3;
   localparam logic [2:0] CL_META  = 3'd4;

   // What the output register loads in a cycle.
   localparam logic [1:0] PUSH_NONE   = 2'd0;
   localparam logic [1:0] PUSH_DIRECT = 2'd1;
   localparam logic [1:0] PUSH_STASH  = 2'd2;
   localparam logic [1:0] PUSH_HELD   = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic [1:0] push;
   } dlc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic dec_rel;
      logic dec_emit;
      logic rel_last;
      logic held_emit;
   } dlc_status_type;

endpackage
`default_nettype wire

[sv/dlc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Diff line classifier channels
// Valid/ready channels for the incoming text words and the tagged result
// words.
// ----------------------------------------------------------------------------
interface dlc_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] in_byte;

   modport source (output valid, output req_type, output in_byte, input ready);
   modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface dlc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] out_class;
   logic       last_of_run;

   modport source (output valid, output out_byte, output out_class,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input out_class,
                   input last_of_run, output ready);
endinterface
`default_nettype wire

[sv/dlc_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Diff line classifier controller
// Sequences one input word: accepts it, then releases held bytes one per
// cycle and finally the deciding byte, if emitted, as the output register frees up.
// ----------------------------------------------------------------------------
module dlc_controller import dlc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire dlc_status_type status,
   output dlc_cmd_type         cmd
);

   localparam logic [1:0] SEQ_IDLE = 2'd0;
   localparam logic [1:0] SEQ_REL  = 2'd1;
   localparam logic [1:0] SEQ_HELD = 2'd2;

   logic [1:0] seq_ff;
   logic [1:0] seq_in;

   // Next sequencer state and the commands of this cycle.
   always_comb begin
      seq_in     = seq_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.push   = PUSH_NONE;
      case (seq_ff)
         SEQ_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               cmd.accept = 1'b1;
               if (status.dec_rel) begin
                  seq_in = SEQ_REL;
               end else if (status.dec_emit) begin
                  cmd.push = PUSH_DIRECT;
               end
            end
         end
         SEQ_REL: begin
            if (status.out_free) begin
               cmd.push = PUSH_STASH;
               if (status.rel_last) begin
                  seq_in = status.held_emit ? SEQ_HELD : SEQ_IDLE;
               end
            end
         end
         SEQ_HELD: begin
            if (status.out_free) begin
               cmd.push = PUSH_HELD;
               seq_in   = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_IDLE;
      end else begin
         seq_ff <= seq_in;
      end
   end

endmodule
`default_nettype wire

[sv/dlc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Diff line classifier datapath
// Holds the parse state, the line-start stash with its running word match,
// the class decision for the offered word, and the output register.
// ----------------------------------------------------------------------------
module dlc_datapath import dlc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dlc_cmd_type cmd,
   input  wire logic        req_type,
   input  wire logic [7:0]  in_byte,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic [7:0]       out_byte,
   output logic [2:0]       out_class,
   output logic             last_of_run,
   output dlc_status_type   status
);

   // Parse states.
   localparam logic [3:0] ST_START = 4'd0;
   localparam logic [3:0] ST_AT    = 4'd1;
   localparam logic [3:0] ST_WORD  = 4'd2;
   localparam logic [3:0] ST_P1    = 4'd3;
   localparam logic [3:0] ST_P2    = 4'd4;
   localparam logic [3:0] ST_M1    = 4'd5;
   localparam logic [3:0] ST_M2    = 4'd6;
   localparam logic [3:0] ST_P3    = 4'd7;
   localparam logic [3:0] ST_M3    = 4'd8;
   localparam logic [3:0] ST_PLAIN = 4'd9;
   localparam logic [3:0] ST_ADD   = 4'd10;
   localparam logic [3:0] ST_REM   = 4'd11;
   localparam logic [3:0] ST_HUNK  = 4'd12;
   localparam logic [3:0] ST_META  = 4'd13;

   // Characters that steer the parse.
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // Metadata word list, left-justified in a field of the longest word.
   localparam int NUM_WORDS    = 11;
   localparam int MAX_WORD_LEN = 13;
   localparam int WORD_TEXT_W  = 8 * MAX_WORD_LEN;
   localparam int WORD_POS_W   = $clog2(MAX_WORD_LEN);

   function automatic logic [WORD_TEXT_W-1:0] word_text(input logic [3:0] k);
      case (k)
         4'd0:    word_text = {"diff", 72'd0};
         4'd1:    word_text = {"index", 64'd0};
         4'd2:    word_text = {"old", 80'd0};
         4'd3:    word_text = {"new", 80'd0};
         4'd4:    word_text = {"deleted", 48'd0};
         4'd5:    word_text = {"copy", 72'd0};
         4'd6:    word_text = {"rename", 56'd0};
         4'd7:    word_text = {"similarity", 24'd0};
         4'd8:    word_text = "dissimilarity";
         4'd9:    word_text = {"Binary", 56'd0};
         4'd10:   word_text = {"GIT", 80'd0};
         default: word_text = '0;
      endcase
   endfunction

   function automatic logic [3:0] word_len(input logic [3:0] k);
      case (k)
         4'd0:    word_len = 4'd4;
         4'd1:    word_len = 4'd5;
         4'd2:    word_len = 4'd3;
         4'd3:    word_len = 4'd3;
         4'd4:    word_len = 4'd7;
         4'd5:    word_len = 4'd4;
         4'd6:    word_len = 4'd6;
         4'd7:    word_len = 4'd10;
         4'd8:    word_len = 4'd13;
         4'd9:    word_len = 4'd6;
         4'd10:   word_len = 4'd3;
         default: word_len = 4'd0;
      endcase
   endfunction

   function automatic logic [7:0] word_char(input logic [3:0] k,
                                            input logic [WORD_POS_W-1:0] pos);
      logic [WORD_TEXT_W-1:0] t;
      t = word_text(k) << {pos, 3'b000};
      word_char = t[WORD_TEXT_W-1 -: 8];
   endfunction

   // Class carried by the bytes of a decided line.
   function automatic logic [2:0] state_cls(input logic [3:0] s);
      case (s)
         ST_ADD:  state_cls = CL_ADD;
         ST_REM:  state_cls = CL_REM;
         ST_HUNK: state_cls = CL_HUNK;
         ST_META: state_cls = CL_META;
         default: state_cls = CL_PLAIN;
      endcase
   endfunction

   logic [3:0]               parse_state_ff, parse_state_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [NUM_WORDS-1:0]     match_ff, match_in;
   logic [7:0]               stash_ff [WORD_LIMIT];
   logic [COUNT_W-1:0]       rel_len_ff, rel_len_in;
   logic [STASH_IDX_W-1:0]   rel_idx_ff, rel_idx_in;
   logic [2:0]               rel_cls_ff, rel_cls_in;
   logic [7:0]               held_byte_ff, held_byte_in;
   logic [2:0]               held_cls_ff, held_cls_in;
   logic                     held_emit_ff, held_emit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_byte_ff, rsp_byte_in;
   logic [2:0]               rsp_cls_ff, rsp_cls_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [3:0]               eff_state;
   logic                     is_letter;
   logic                     is_space;
   logic                     word_meta;
   logic                     rel_last;
   logic                     out_free;
   logic                     stash_we;
   logic [STASH_IDX_W-1:0]   stash_wa;

   logic                     d_rel, d_emit, d_start, d_append, d_line;
   logic [2:0]               d_rel_cls, d_emit_cls;
   logic [3:0]               d_next, d_line_st;

   // Byte classes and the running word match.
   always_comb begin
      is_letter = (in_byte >= "a" && in_byte <= "z") ||
                  (in_byte >= "A" && in_byte <= "Z");
      is_space  = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_NL);
      word_meta = 1'b0;
      for (int k = 0; k < NUM_WORDS; k++) begin
         if (match_ff[k] && count_ff == COUNT_W'(word_len(4'(k)))) begin
            word_meta = 1'b1;
         end
      end
      eff_state = (parse_state_ff > ST_META) ? ST_START : parse_state_ff;
   end

   // Class decision for the offered word.
   always_comb begin
      d_rel      = 1'b0;
      d_rel_cls  = CL_PLAIN;
      d_emit     = 1'b0;
      d_emit_cls = CL_PLAIN;
      d_start    = 1'b0;
      d_append   = 1'b0;
      d_line     = 1'b0;
      d_line_st  = ST_PLAIN;
      d_next     = eff_state;
      if (req_type) begin
         // Flush: release the stash by best guess, back to line start.
         d_next = ST_START;
         case (eff_state)
            ST_P1, ST_P2: begin
               d_rel = 1'b1; d_rel_cls = CL_ADD;
            end
            ST_M1, ST_M2: begin
               d_rel = 1'b1; d_rel_cls = CL_REM;
            end
            ST_P3, ST_M3: begin
               d_rel = 1'b1; d_rel_cls = CL_META;
            end
            ST_WORD: begin
               d_rel = 1'b1; d_rel_cls = word_meta ? CL_META : CL_PLAIN;
            end
            ST_AT: begin
               d_rel = 1'b1; d_rel_cls = CL_PLAIN;
            end
            default: begin
               d_rel = 1'b0;
            end
         endcase
      end else begin
         case (eff_state)
            ST_START: begin
               if (in_byte == CH_PLUS) begin
                  d_start = 1'b1; d_next = ST_P1;
               end else if (in_byte == CH_MINUS) begin
                  d_start = 1'b1; d_next = ST_M1;
               end else if (in_byte == CH_BSLASH) begin
                  d_line = 1'b1; d_line_st = ST_META;
               end else if (in_byte == CH_AT) begin
                  d_start = 1'b1; d_next = ST_AT;
               end else if (is_letter) begin
                  d_start = 1'b1; d_next = ST_WORD;
               end else begin
                  d_line = 1'b1; d_line_st = ST_PLAIN;
               end
            end
            ST_AT: begin
               d_rel  = 1'b1;
               d_line = 1'b1;
               if (in_byte == CH_AT) begin
                  d_rel_cls = CL_HUNK; d_line_st = ST_HUNK;
               end else begin
                  d_rel_cls = CL_PLAIN; d_line_st = ST_PLAIN;
               end
            end
            ST_WORD: begin
               if (is_letter && count_ff < COUNT_W'(WORD_LIMIT)) begin
                  d_append = 1'b1;
               end else if (!is_letter && word_meta) begin
                  d_rel = 1'b1; d_rel_cls = CL_META;
                  d_line = 1'b1; d_line_st = ST_META;
               end else begin
                  d_rel = 1'b1; d_rel_cls = CL_PLAIN;
                  d_line = 1'b1; d_line_st = ST_PLAIN;
               end
            end
            ST_P1, ST_P2: begin
               if (in_byte == CH_PLUS) begin
                  d_append = 1'b1;
                  d_next   = (eff_state == ST_P1) ? ST_P2 : ST_P3;
               end else begin
                  d_rel = 1'b1; d_rel_cls = CL_ADD;
                  d_line = 1'b1; d_line_st = ST_ADD;
               end
            end
            ST_M1, ST_M2: begin
               if (in_byte == CH_MINUS) begin
                  d_append = 1'b1;
                  d_next   = (eff_state == ST_M1) ? ST_M2 : ST_M3;
               end else begin
                  d_rel = 1'b1; d_rel_cls = CL_REM;
                  d_line = 1'b1; d_line_st = ST_REM;
               end
            end
            ST_P3, ST_M3: begin
               d_rel  = 1'b1;
               d_line = 1'b1;
               if (is_space) begin
                  d_rel_cls = CL_META; d_line_st = ST_META;
               end else if (eff_state == ST_P3) begin
                  d_rel_cls = CL_ADD; d_line_st = ST_ADD;
               end else begin
                  d_rel_cls = CL_REM; d_line_st = ST_REM;
               end
            end
            ST_PLAIN, ST_ADD, ST_REM, ST_HUNK, ST_META: begin
               d_line = 1'b1; d_line_st = eff_state;
            end
            default: begin
               d_next = ST_START;
            end
         endcase
      end
      // A byte inside a decided line carries its class; a newline ends it.
      if (d_line) begin
         d_emit     = 1'b1;
         d_emit_cls = state_cls(d_line_st);
         d_next     = (in_byte == CH_NL) ? ST_START : d_line_st;
      end
   end

   // Parse state, stash bookkeeping and the release setup.
   always_comb begin
      parse_state_in = parse_state_ff;
      count_in       = count_ff;
      match_in       = match_ff;
      rel_len_in     = rel_len_ff;
      rel_idx_in     = rel_idx_ff;
      rel_cls_in     = rel_cls_ff;
      held_byte_in   = held_byte_ff;
      held_cls_in    = held_cls_ff;
      held_emit_in   = held_emit_ff;
      stash_we       = 1'b0;
      stash_wa       = count_ff[STASH_IDX_W-1:0];
      if (cmd.accept) begin
         parse_state_in = d_next;
         if (req_type) begin
            count_in = '0;
         end
         if (d_start) begin
            stash_we = 1'b1;
            stash_wa = '0;
            count_in = COUNT_W'(1);
            for (int k = 0; k < NUM_WORDS; k++) begin
               match_in[k] = (word_char(4'(k), '0) == in_byte);
            end
         end
         if (d_append) begin
            stash_we = 1'b1;
            count_in = count_ff + COUNT_W'(1);
            for (int k = 0; k < NUM_WORDS; k++) begin
               match_in[k] = match_ff[k] &&
                             (count_ff < COUNT_W'(word_len(4'(k)))) &&
                             (word_char(4'(k), count_ff[WORD_POS_W-1:0]) == in_byte);
            end
         end
         if (d_rel) begin
            rel_len_in   = count_ff;
            rel_idx_in   = '0;
            rel_cls_in   = d_rel_cls;
            held_byte_in = in_byte;
            held_cls_in  = d_emit_cls;
            held_emit_in = d_emit;
            count_in     = '0;
         end
      end
      if (cmd.push == PUSH_STASH) begin
         rel_idx_in = rel_idx_ff + STASH_IDX_W'(1);
      end
   end

   assign rel_last = (COUNT_W'(rel_idx_ff) + COUNT_W'(1)) == rel_len_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Output register: loads one result word per push.
   always_comb begin
      rsp_byte_in  = rsp_byte_ff;
      rsp_cls_in   = rsp_cls_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.push)
         PUSH_DIRECT: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = in_byte;
            rsp_cls_in   = d_emit_cls;
            rsp_last_in  = 1'b1;
         end
         PUSH_STASH: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = stash_ff[rel_idx_ff];
            rsp_cls_in   = rel_cls_ff;
            rsp_last_in  = rel_last && !held_emit_ff;
         end
         PUSH_HELD: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = held_byte_ff;
            rsp_cls_in   = held_cls_ff;
            rsp_last_in  = 1'b1;
         end
         default: begin
            rsp_byte_in = rsp_byte_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         parse_state_ff <= ST_START;
         count_ff       <= '0;
         rel_idx_ff     <= '0;
         rel_len_ff     <= '0;
         held_emit_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         parse_state_ff <= parse_state_in;
         count_ff       <= count_in;
         rel_idx_ff     <= rel_idx_in;
         rel_len_ff     <= rel_len_in;
         held_emit_ff   <= held_emit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      match_ff     <= match_in;
      rel_cls_ff   <= rel_cls_in;
      held_byte_ff <= held_byte_in;
      held_cls_ff  <= held_cls_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_cls_ff   <= rsp_cls_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Line-start stash.
   always_ff @(posedge clock) begin
      if (stash_we) begin
         stash_ff[stash_wa] <= in_byte;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign out_byte    = rsp_byte_ff;
   assign out_class   = rsp_cls_ff;
   assign last_of_run = rsp_last_ff;

   assign status.out_free  = out_free;
   assign status.dec_rel   = d_rel;
   assign status.dec_emit  = d_emit;
   assign status.rel_last  = rel_last;
   assign status.held_emit = held_emit_ff;

endmodule
`default_nettype wire

[sv/diff_line_classifier.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Diff line classifier
// Tags every byte of a unified-diff stream with the class of its line.
// ----------------------------------------------------------------------------
// A byte inside a line whose class is already known is accepted and shows
// up on the result channel the next cycle, so such text streams at one
// byte per cycle while the result channel is ready. A byte at line start
// that cannot yet be decided (a leading +, -, @ or letter word of up to 16
// letters) is held and gives no result word. Once the byte that decides the
// class is accepted, the n held bytes and then the deciding byte leave
// through the single output register one word per cycle as it frees up,
// and no new word is accepted before they have all left. A flush word
// releases any held bytes the same way and returns to line start. The last
// word caused by an input carries last_of_run. No clearing pass follows
// reset.
// ----------------------------------------------------------------------------
module diff_line_classifier import dlc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dlc_req_if.sink   req_ch,
   dlc_rsp_if.source rsp_ch
);

   dlc_cmd_type    cmd;
   dlc_status_type status;
   logic           req_ready;

   dlc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dlc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_type    (req_ch.req_type),
      .in_byte     (req_ch.in_byte),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .out_byte    (rsp_ch.out_byte),
      .out_class   (rsp_ch.out_class),
      .last_of_run (rsp_ch.last_of_run),
      .status      (status)
   );

   assign req_ch.ready = req_ready;

endmodule
`default_nettype wire

[sv/dlc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Diff line classifier checker
// Port-level checks on the result channel and its relation to the input.
// ----------------------------------------------------------------------------
module dlc_checker import dlc_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] out_byte,
   input wire logic [2:0] out_class,
   input wire logic       last_of_run
);

   // A stalled result word holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) &&
      $stable(out_class) && $stable(last_of_run))
   else $error("result word changed while stalled");

   // While a run is unfinished no new input word is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_of_run |-> !req_ready)
   else $error("input taken in the middle of a result run");

   // Reset empties the output register.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
   else $error("result valid right after reset");

   // Only the five line classes appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> out_class <= CL_META)
   else $error("result carries an unknown class");

endmodule

bind diff_line_classifier dlc_checker u_dlc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .out_byte    (rsp_ch.out_byte),
   .out_class   (rsp_ch.out_class),
   .last_of_run (rsp_ch.last_of_run)
);
`default_nettype wire
